/* src/ctlp_pkg.sv */
// Package for the cheat text line parser.
// Holds the action and line-kind codes and the record types passed between the
// front end, the line queue and the back end. It depends on nothing else.
package ctlp_pkg;

  // A line piece is cut once this many bytes are in it.
  localparam int unsigned LINE_CHARS = 255;

  // Action codes on the input side.
  localparam logic [1:0] ACT_BYTE  = 2'd0;
  localparam logic [1:0] ACT_END   = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // Line kinds.
  localparam logic [1:0] KIND_TITLE = 2'd0;
  localparam logic [1:0] KIND_DESC  = 2'd1;
  localparam logic [1:0] KIND_CODE  = 2'd2;

  // One finished line piece, or a start marker, as the front end hands it on.
  typedef struct packed {
    logic        is_start;
    logic        has_text;
    logic [1:0]  kind;
    logic [7:0]  first_pos;
    logic [7:0]  len;
    logic [63:0] digits;
  } line_rec_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  line_kind;
    logic [15:0] line_number;
    logic [31:0] code_address;
    logic [31:0] code_value;
    logic [7:0]  text_start;
    logic [7:0]  text_length;
    logic        status;
    logic [1:0]  expected_kind;
  } result_t;

endpackage

/* src/cheat_text_line_parser.sv */
// Top level of the cheat text line parser.
// Instantiates ctlp_front, ctlp_line_fifo and ctlp_back; depends on ctlp_pkg.

// The parser takes one beat per clock cycle while full is low: a text byte, an
// end of text or a start of a new text. The front end follows the current line
// piece byte by byte (comment cuts at "//" and '#', whitespace trimming, hex
// digit capture) and at each line feed, long-line cut, or end of text or zero
// byte after bytes of the piece it writes one line record into a four-entry
// line queue. The back end reads one record per cycle while the result queue
// has room, checks the title/description/code grammar, counts lines and places
// a result beat into a two-entry result queue, whose head is shown on the
// result ports while empty is low. Empty lines give no result beat but are
// counted. After the first refused line the parser drops everything until a
// start beat. Sustained rate is one input beat per cycle; full rises only when
// four line records are waiting because results are not being popped. A line's
// record passes through the line queue and its result through the result queue.
module cheat_text_line_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [7:0]  ch_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  line_kind_o,
  output logic [15:0] line_number_o,
  output logic [31:0] code_address_o,
  output logic [31:0] code_value_o,
  output logic [7:0]  text_start_o,
  output logic [7:0]  text_length_o,
  output logic        status_o,
  output logic [1:0]  expected_kind_o
);

  logic                accept;
  logic                rec_push;
  ctlp_pkg::line_rec_t rec_in;
  ctlp_pkg::line_rec_t rec_out;
  logic                rec_valid;
  logic                rec_pop;
  ctlp_pkg::result_t   res;

  // An input beat is taken whenever the line queue has room.
  assign accept = push && !full;

  ctlp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .action_i   (action_i),
    .ch_i       (ch_i),
    .rec_push_o (rec_push),
    .rec_o      (rec_in)
  );

  ctlp_line_fifo u_line_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .data_i  (rec_in),
    .full_o  (full),
    .pop_i   (rec_pop),
    .valid_o (rec_valid),
    .data_o  (rec_out)
  );

  ctlp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_i       (rec_out),
    .rec_pop_o   (rec_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign line_kind_o     = res.line_kind;
  assign line_number_o   = res.line_number;
  assign code_address_o  = res.code_address;
  assign code_value_o    = res.code_value;
  assign text_start_o    = res.text_start;
  assign text_length_o   = res.text_length;
  assign status_o        = res.status;
  assign expected_kind_o = res.expected_kind;

endmodule

/* src/ctlp_front.sv */
// Front end of the cheat text line parser: takes bytes, tracks the current
// line piece (comments, trimming, hex digits) and emits one record per piece.
// Depends on ctlp_pkg.
module ctlp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [1:0]          action_i,
  input  logic [7:0]          ch_i,
  output logic                rec_push_o,
  output ctlp_pkg::line_rec_t rec_o
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef struct packed {
    logic [7:0]  char_pos;
    logic        in_comment;
    logic        pending_slash;
    logic        seen_text;
    logic [7:0]  first_pos;
    logic [7:0]  last_pos;
    logic        first_is_quote;
    logic        last_is_quote;
    logic [4:0]  hex_count;
    logic        non_hex_seen;
    logic [63:0] digit_shift;
  } piece_t;

  localparam piece_t PIECE_CLEAR = '0;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
  endfunction

  // Returns {valid, nibble}.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] h;
    h = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      h = {1'b1, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      h = {1'b1, 4'(c - 8'h57)};
    end
    return h;
  endfunction

  function automatic piece_t keep_char(input piece_t s, input logic [7:0] c,
                                       input logic [7:0] pos);
    piece_t     r;
    logic [4:0] h;
    logic       sp;
    r  = s;
    h  = hex_value(c);
    sp = is_space(c);
    if (!sp) begin
      if (!s.seen_text) begin
        r.seen_text      = 1'b1;
        r.first_pos      = pos;
        r.first_is_quote = (c == CH_QUOTE);
      end
      r.last_pos      = pos;
      r.last_is_quote = (c == CH_QUOTE);
    end
    if (h[4]) begin
      if (s.hex_count < 5'd16) begin
        r.digit_shift = {s.digit_shift[59:0], h[3:0]};
      end
      if (s.hex_count < 5'd17) begin
        r.hex_count = s.hex_count + 5'd1;
      end
    end else if (!sp) begin
      r.non_hex_seen = 1'b1;
    end
    return r;
  endfunction

  function automatic piece_t feed_char(input piece_t s, input logic [7:0] c);
    piece_t r;
    r = s;
    r.char_pos = s.char_pos + 8'd1;
    if (!s.in_comment) begin
      if (s.pending_slash && (c == CH_SLASH)) begin
        r.pending_slash = 1'b0;
        r.in_comment    = 1'b1;
      end else begin
        if (s.pending_slash) begin
          r.pending_slash = 1'b0;
          r = keep_char(r, CH_SLASH, s.char_pos - 8'd1);
        end
        if (c == CH_HASH) begin
          r.in_comment = 1'b1;
        end else if (c == CH_SLASH) begin
          r.pending_slash = 1'b1;
        end else begin
          r = keep_char(r, c, s.char_pos);
        end
      end
    end
    return r;
  endfunction

  function automatic ctlp_pkg::line_rec_t finish(input piece_t s);
    piece_t              t;
    ctlp_pkg::line_rec_t rec;
    t = s;
    // A lone slash at the end of a piece counts as text.
    if (s.pending_slash && !s.in_comment && (s.char_pos != 8'd0)) begin
      t = keep_char(s, CH_SLASH, s.char_pos - 8'd1);
    end
    rec           = '0;
    rec.has_text  = t.seen_text;
    rec.first_pos = t.first_pos;
    rec.len       = t.last_pos - t.first_pos + 8'd1;
    rec.digits    = t.digit_shift;
    if ((rec.len > 8'd2) && t.first_is_quote && t.last_is_quote) begin
      rec.kind = ctlp_pkg::KIND_TITLE;
    end else if ((t.hex_count == 5'd16) && !t.non_hex_seen) begin
      rec.kind = ctlp_pkg::KIND_CODE;
    end else begin
      rec.kind = ctlp_pkg::KIND_DESC;
    end
    return rec;
  endfunction

  piece_t              piece_q, piece_d;
  ctlp_pkg::line_rec_t fin_rec;
  ctlp_pkg::line_rec_t start_rec;

  assign fin_rec = finish(piece_q);

  always_comb begin
    start_rec          = '0;
    start_rec.is_start = 1'b1;
  end

  always_comb begin
    piece_d    = piece_q;
    rec_push_o = 1'b0;
    rec_o      = fin_rec;
    if (accept_i) begin
      case (action_i)
        ctlp_pkg::ACT_START: begin
          piece_d    = PIECE_CLEAR;
          rec_push_o = 1'b1;
          rec_o      = start_rec;
        end
        ctlp_pkg::ACT_END: begin
          if (piece_q.char_pos != 8'd0) begin
            rec_push_o = 1'b1;
            piece_d    = PIECE_CLEAR;
          end
        end
        ctlp_pkg::ACT_BYTE: begin
          if (ch_i == CH_NUL) begin
            if (piece_q.char_pos != 8'd0) begin
              rec_push_o = 1'b1;
              piece_d    = PIECE_CLEAR;
            end
          end else if (ch_i == CH_LF) begin
            rec_push_o = 1'b1;
            piece_d    = PIECE_CLEAR;
          end else if (piece_q.char_pos >= 8'(ctlp_pkg::LINE_CHARS)) begin
            rec_push_o = 1'b1;
            piece_d    = feed_char(PIECE_CLEAR, ch_i);
          end else begin
            piece_d = feed_char(piece_q, ch_i);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piece_q <= PIECE_CLEAR;
    end else begin
      piece_q <= piece_d;
    end
  end

endmodule

/* src/ctlp_line_fifo.sv */
// Short queue of line records between the front end and the back end.
// Depends on ctlp_pkg for the record type.
module ctlp_line_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ctlp_pkg::line_rec_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output ctlp_pkg::line_rec_t data_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ctlp_pkg::line_rec_t mem_q [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]    count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* src/ctlp_back.sv */
// Back end of the cheat text line parser: checks each line record against the
// title/description/code grammar, counts lines and queues the results.
// Depends on ctlp_pkg.
module ctlp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  input  ctlp_pkg::line_rec_t rec_i,
  output logic                rec_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output ctlp_pkg::result_t   res_o
);

  localparam logic [2:0] SET_TITLE = 3'b001;
  localparam logic [2:0] SET_DESC  = 3'b010;
  localparam logic [2:0] SET_CODE  = 3'b100;
  localparam logic [2:0] SET_ALL   = SET_TITLE | SET_DESC | SET_CODE;

  logic [2:0]        exp_set_q, exp_set_d;
  logic [15:0]       line_cnt_q, line_cnt_d;
  logic              halted_q, halted_d;
  logic [2:0]        kind_bit;
  logic              ok;
  logic              res_push;
  ctlp_pkg::result_t res;

  // Two-entry result queue.
  ctlp_pkg::result_t oq_q [2];
  logic              oq_wr_q, oq_rd_q;
  logic [1:0]        oq_cnt_q;
  logic              oq_full, oq_pop;

  assign oq_full   = (oq_cnt_q == 2'd2);
  assign empty_o   = (oq_cnt_q == 2'd0);
  assign res_o     = oq_q[oq_rd_q];
  assign oq_pop    = pop_i && !empty_o;
  assign rec_pop_o = rec_valid_i && !oq_full;

  always_comb begin
    case (rec_i.kind)
      ctlp_pkg::KIND_TITLE: kind_bit = SET_TITLE;
      ctlp_pkg::KIND_CODE:  kind_bit = SET_CODE;
      default:              kind_bit = SET_DESC;
    endcase
    ok = (exp_set_q & kind_bit) != 3'b000;

    res               = '0;
    res.line_kind     = rec_i.kind;
    res.line_number   = line_cnt_q;
    res.text_start    = rec_i.first_pos;
    res.text_length   = rec_i.len;
    res.status        = !ok;
    if (rec_i.kind == ctlp_pkg::KIND_CODE) begin
      res.code_address = rec_i.digits[63:32];
      res.code_value   = rec_i.digits[31:0];
    end
    if (!ok) begin
      if ((exp_set_q & SET_CODE) != 3'b000) begin
        res.expected_kind = ctlp_pkg::KIND_CODE;
      end else if ((exp_set_q & SET_DESC) != 3'b000) begin
        res.expected_kind = ctlp_pkg::KIND_DESC;
      end else begin
        res.expected_kind = ctlp_pkg::KIND_TITLE;
      end
    end

    exp_set_d  = exp_set_q;
    line_cnt_d = line_cnt_q;
    halted_d   = halted_q;
    res_push   = 1'b0;
    if (rec_pop_o) begin
      if (rec_i.is_start) begin
        exp_set_d  = SET_TITLE;
        line_cnt_d = 16'd1;
        halted_d   = 1'b0;
      end else if (!halted_q) begin
        if (rec_i.has_text) begin
          res_push = 1'b1;
          if (!ok) begin
            halted_d = 1'b1;
          end else if (rec_i.kind == ctlp_pkg::KIND_TITLE) begin
            exp_set_d = SET_TITLE | SET_DESC;
          end else begin
            exp_set_d = SET_ALL;
          end
        end
        if (line_cnt_q != 16'hFFFF) begin
          line_cnt_d = line_cnt_q + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      oq_q[oq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_set_q  <= SET_TITLE;
      line_cnt_q <= 16'd1;
      halted_q   <= 1'b0;
      oq_wr_q    <= 1'b0;
      oq_rd_q    <= 1'b0;
      oq_cnt_q   <= 2'd0;
    end else begin
      exp_set_q  <= exp_set_d;
      line_cnt_q <= line_cnt_d;
      halted_q   <= halted_d;
      if (res_push) begin
        oq_wr_q <= !oq_wr_q;
      end
      if (oq_pop) begin
        oq_rd_q <= !oq_rd_q;
      end
      if (res_push && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + 2'd1;
      end else if (oq_pop && !res_push) begin
        oq_cnt_q <= oq_cnt_q - 2'd1;
      end
    end
  end

endmodule

/* tb/cheat_text_line_parser_test.sv */
// Self-checking testbench for cheat_text_line_parser.
// Drives text beats on the push/full side, predicts each result line with its own parser
// model and checks every beat popped from the result side; depends on ctlp_pkg and the parser's top level.
module cheat_text_line_parser_test;

  // The fourth action code has no meaning and must be ignored by the block.
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // One bit per line kind in the set of kinds the grammar allows next.
  localparam logic [2:0] ALLOW_TITLE = 3'b001;
  localparam logic [2:0] ALLOW_DESC  = 3'b010;
  localparam logic [2:0] ALLOW_CODE  = 3'b100;

  localparam logic [4:0] NOT_HEX = 5'h10;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] ch;
  } text_beat_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        push     = 1'b0;
  logic        pop      = 1'b0;
  logic [1:0]  action_i = ctlp_pkg::ACT_BYTE;
  logic [7:0]  ch_i     = 8'h00;
  logic        full;
  logic        empty;
  logic [1:0]  line_kind_o;
  logic [15:0] line_number_o;
  logic [31:0] code_address_o;
  logic [31:0] code_value_o;
  logic [7:0]  text_start_o;
  logic [7:0]  text_length_o;
  logic        status_o;
  logic [1:0]  expected_kind_o;

  cheat_text_line_parser uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .action_i        (action_i),
    .ch_i            (ch_i),
    .empty           (empty),
    .pop             (pop),
    .line_kind_o     (line_kind_o),
    .line_number_o   (line_number_o),
    .code_address_o  (code_address_o),
    .code_value_o    (code_value_o),
    .text_start_o    (text_start_o),
    .text_length_o   (text_length_o),
    .status_o        (status_o),
    .expected_kind_o (expected_kind_o)
  );

  // Beats waiting to be offered, and result lines predicted but not yet popped.
  text_beat_t          bytes_to_send[$];
  ctlp_pkg::result_t   lines_due[$];

  // Idle percentages for each side, and the long receiver hold used to fill the block.
  int send_idle_pct = 0;
  int take_idle_pct = 0;
  bit rx_held       = 1'b0;

  int mismatches     = 0;
  int beats_queued   = 0;
  int line_ends      = 0;
  int beats_taken    = 0;
  int lines_checked  = 0;
  int refusals_seen  = 0;
  int top_line       = 0;
  bit input_stalled  = 1'b0;

  // ---------------------------------------------------------------------------------------
  // Parser model. It tracks the current line piece exactly as the block must: position in
  // the piece, comment state, a held '/' that may open a "//" comment, the first and last
  // kept characters, and the hex digits seen. Whole-line state is the grammar set, the
  // line counter and the halt flag.
  // ---------------------------------------------------------------------------------------
  logic [2:0]  allowed_kinds;
  logic [15:0] line_no;
  logic        parse_halted;
  logic [7:0]  piece_pos;
  logic        in_remark;
  logic        slash_held;
  logic        have_text;
  logic [7:0]  text_first;
  logic [7:0]  text_last;
  logic        first_quote;
  logic        last_quote;
  logic [4:0]  hex_digits;
  logic        other_seen;
  logic [63:0] hex_shift;

  function automatic void clear_piece();
    piece_pos   = 8'd0;
    in_remark   = 1'b0;
    slash_held  = 1'b0;
    have_text   = 1'b0;
    text_first  = 8'd0;
    text_last   = 8'd0;
    first_quote = 1'b0;
    last_quote  = 1'b0;
    hex_digits  = 5'd0;
    other_seen  = 1'b0;
    hex_shift   = 64'd0;
  endfunction

  function automatic void restart_parse();
    allowed_kinds = ALLOW_TITLE;
    line_no       = 16'd1;
    parse_halted  = 1'b0;
    clear_piece();
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= 8'h0D);
  endfunction

  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
    return NOT_HEX;
  endfunction

  // A character that survived comment stripping at position pos of the piece.
  function automatic void keep_byte(logic [7:0] c, logic [7:0] pos);
    logic [4:0] nib;
    nib = hex_nibble(c);
    if (!is_blank(c)) begin
      if (!have_text) begin
        have_text   = 1'b1;
        text_first  = pos;
        first_quote = (c == CH_QUOTE);
      end
      text_last  = pos;
      last_quote = (c == CH_QUOTE);
    end
    if (nib != NOT_HEX) begin
      if (hex_digits < 5'd16) hex_shift = {hex_shift[59:0], nib[3:0]};
      if (hex_digits < 5'd17) hex_digits = hex_digits + 5'd1;
    end else if (!is_blank(c)) begin
      other_seen = 1'b1;
    end
  endfunction

  function automatic void take_byte(logic [7:0] c);
    logic [7:0] pos;
    pos       = piece_pos;
    piece_pos = piece_pos + 8'd1;
    if (in_remark) return;
    if (slash_held) begin
      slash_held = 1'b0;
      if (c == CH_SLASH) begin
        in_remark = 1'b1;
        return;
      end
      keep_byte(CH_SLASH, pos - 8'd1);
    end
    if (c == CH_HASH) begin
      in_remark = 1'b1;
      return;
    end
    if (c == CH_SLASH) begin
      slash_held = 1'b1;
      return;
    end
    keep_byte(c, pos);
  endfunction

  // Ends the current piece: classifies it, checks the grammar and records the result.
  function automatic void close_piece();
    ctlp_pkg::result_t res;
    logic [8:0]        span;
    logic [1:0]        kind;
    logic [2:0]        kind_mask;
    logic              ok;
    // A '/' still held at the end of a piece never opened a comment, so it is text.
    if (slash_held && !in_remark && piece_pos != 8'd0) keep_byte(CH_SLASH, piece_pos - 8'd1);
    slash_held = 1'b0;
    if (have_text) begin
      span = {1'b0, text_last} - {1'b0, text_first} + 9'd1;
      if (span > 9'd2 && first_quote && last_quote) begin
        kind      = ctlp_pkg::KIND_TITLE;
        kind_mask = ALLOW_TITLE;
      end else if (hex_digits == 5'd16 && !other_seen) begin
        kind      = ctlp_pkg::KIND_CODE;
        kind_mask = ALLOW_CODE;
      end else begin
        kind      = ctlp_pkg::KIND_DESC;
        kind_mask = ALLOW_DESC;
      end
      ok = (allowed_kinds & kind_mask) != 3'b000;
      res.expected_kind = ctlp_pkg::KIND_TITLE;
      if (!ok) begin
        if (allowed_kinds & ALLOW_CODE) res.expected_kind = ctlp_pkg::KIND_CODE;
        else if (allowed_kinds & ALLOW_DESC) res.expected_kind = ctlp_pkg::KIND_DESC;
        parse_halted = 1'b1;
      end else if (kind == ctlp_pkg::KIND_TITLE) begin
        allowed_kinds = ALLOW_TITLE | ALLOW_DESC;
      end else begin
        allowed_kinds = ALLOW_TITLE | ALLOW_DESC | ALLOW_CODE;
      end
      res.line_kind    = kind;
      res.line_number  = line_no;
      res.code_address = (kind == ctlp_pkg::KIND_CODE) ? hex_shift[63:32] : 32'd0;
      res.code_value   = (kind == ctlp_pkg::KIND_CODE) ? hex_shift[31:0] : 32'd0;
      res.text_start   = text_first;
      res.text_length  = span[7:0];
      res.status       = !ok;
      lines_due.push_back(res);
    end
    if (line_no != 16'hFFFF) line_no = line_no + 16'd1;
    clear_piece();
  endfunction

  // Applies one accepted input beat to the model.
  function automatic void parse_beat(logic [1:0] act, logic [7:0] c);
    if (act == ctlp_pkg::ACT_START) begin
      restart_parse();
      return;
    end
    if (act == ACT_SPARE || parse_halted) return;
    if (act == ctlp_pkg::ACT_END || c == CH_NUL) begin
      if (piece_pos != 8'd0) close_piece();
      return;
    end
    if (c == CH_LF) begin
      close_piece();
      return;
    end
    // A full piece is cut before the new byte; the byte is dropped if the cut halts.
    if (piece_pos >= ctlp_pkg::LINE_CHARS) begin
      close_piece();
      if (parse_halted) return;
    end
    take_byte(c);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus builders. They only append beats to the send queue.
  // ---------------------------------------------------------------------------------------
  task automatic add_beat(logic [1:0] act, logic [7:0] c);
    text_beat_t b;
    b.action = act;
    b.ch     = c;
    bytes_to_send.push_back(b);
    beats_queued++;
  endtask

  task automatic add_byte(logic [7:0] c);
    add_beat(ctlp_pkg::ACT_BYTE, c);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_run(logic [7:0] c, int n);
    repeat (n) add_byte(c);
  endtask

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0, 1:    return CH_SPACE;
      2:       return CH_TAB;
      3:       return 8'h0B;
      4:       return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  // Printable-ish text with a fair share of hex digits, blanks, comment starters, quotes
  // and bytes above 127. It never yields a line feed or a zero byte.
  function automatic logic [7:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    if (r < 60) return 8'h30 + 8'($urandom_range(0, 9));
    if (r < 72) return blank_byte();
    if (r < 77) return CH_SLASH;
    if (r < 80) return CH_HASH;
    if (r < 87) return CH_QUOTE;
    if (r < 93) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  task automatic end_line();
    int r;
    r = $urandom_range(0, 19);
    if (r < 16) add_byte(CH_LF);
    else if (r < 18) add_beat(ctlp_pkg::ACT_END, 8'($urandom_range(0, 255)));
    else add_byte(CH_NUL);
    line_ends++;
  endtask

  task automatic add_blanks();
    repeat ($urandom_range(1, 3)) add_byte(blank_byte());
  endtask

  task automatic add_remark();
    if ($urandom_range(0, 1)) begin
      add_byte(CH_HASH);
    end else begin
      add_byte(CH_SLASH);
      add_byte(CH_SLASH);
    end
    repeat ($urandom_range(0, 6)) add_byte(text_byte());
  endtask

  task automatic add_code_line();
    int         digits;
    int         pattern;
    logic [3:0] v;
    digits  = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 15 : 17) : 16;
    pattern = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) add_blanks();
    for (int i = 0; i < digits; i++) begin
      v = (pattern == 0) ? 4'h0 : (pattern == 1) ? 4'hF : 4'($urandom_range(0, 15));
      if ($urandom_range(0, 3) == 0) add_byte(blank_byte());
      add_byte(hex_char(v));
    end
    if ($urandom_range(0, 3) == 0) add_blanks();
    if ($urandom_range(0, 4) == 0) add_remark();
    end_line();
  endtask

  task automatic add_title_line();
    if ($urandom_range(0, 3) == 0) add_blanks();
    add_byte(CH_QUOTE);
    repeat ($urandom_range(0, 10)) add_byte(text_byte());
    add_byte(CH_QUOTE);
    if ($urandom_range(0, 3) == 0) add_blanks();
    if ($urandom_range(0, 5) == 0) add_remark();
    end_line();
  endtask

  task automatic add_desc_line();
    repeat ($urandom_range(1, 20)) add_byte(text_byte());
    if ($urandom_range(0, 4) == 0) add_remark();
    end_line();
  endtask

  task automatic add_empty_line();
    if ($urandom_range(0, 1)) add_blanks();
    if ($urandom_range(0, 1)) add_remark();
    end_line();
  endtask

  task automatic add_any_line();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_code_line();
      4, 5:       add_desc_line();
      6:          add_title_line();
      7:          add_empty_line();
      default:    add_desc_line();
    endcase
  endtask

  // A text built as start, title line, description lines, then a random mix of lines.
  task automatic add_story();
    add_beat(ctlp_pkg::ACT_START, 8'($urandom_range(0, 255)));
    add_title_line();
    repeat ($urandom_range(1, 2)) add_desc_line();
    repeat ($urandom_range(2, 6)) add_any_line();
  endtask

  task automatic add_random_sequence();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      add_story();
    end else if (r < 84) begin
      // Lines with no start in front; they may follow a halt or break the grammar.
      repeat ($urandom_range(1, 4)) add_any_line();
    end else if (r < 96) begin
      repeat ($urandom_range(4, 24)) begin
        add_beat(($urandom_range(0, 5) != 0) ? ctlp_pkg::ACT_BYTE : 2'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(256, 320)) add_byte(text_byte());
      end_line();
    end
  endtask

  // The sender stops here until everything queued is taken and every result has come.
  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || lines_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(int send_pct, int take_pct);
    send_idle_pct = send_pct;
    take_idle_pct = take_pct;
  endtask

  // ---------------------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 200) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want,
                             logic [15:0] line);
    if (got !== want) begin
      report_mismatch($sformatf("line %0d: %s is %0h, expected %0h", line, name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------------------------
  // Clock, driver and monitor.
  // ---------------------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Driver: both sides change at the falling edge. The sender offers the head of the queue
  // unless it idles this cycle; the receiver pops unless it idles or is being held off.
  always @(negedge clk_i) begin
    if (rst_ni && bytes_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      push     <= 1'b1;
      action_i <= bytes_to_send[0].action;
      ch_i     <= bytes_to_send[0].ch;
    end else begin
      push <= 1'b0;
    end
    pop <= rst_ni && !rx_held && ($urandom_range(0, 99) >= take_idle_pct);
  end

  // Monitor: at the rising edge it first checks a popped result beat against the oldest
  // predicted line, then feeds an accepted input beat to the model. A result passes both
  // queues after its beat, so a prediction is never needed at the edge it is made.
  always @(posedge clk_i) begin : watch_ports
    ctlp_pkg::result_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        lines_checked++;
        if (status_o) refusals_seen++;
        if (int'(line_number_o) > top_line) top_line = int'(line_number_o);
        if (lines_due.size() == 0) begin
          report_mismatch($sformatf("result beat for line %0d with no line due",
                                    line_number_o));
        end else begin
          want = lines_due.pop_front();
          check_field("line_kind", line_kind_o, want.line_kind, want.line_number);
          check_field("line_number", line_number_o, want.line_number, want.line_number);
          check_field("code_address", code_address_o, want.code_address, want.line_number);
          check_field("code_value", code_value_o, want.code_value, want.line_number);
          check_field("text_start", text_start_o, want.text_start, want.line_number);
          check_field("text_length", text_length_o, want.text_length, want.line_number);
          check_field("status", status_o, want.status, want.line_number);
          check_field("expected_kind", expected_kind_o, want.expected_kind,
                      want.line_number);
        end
      end
      if (push && full) input_stalled = 1'b1;
      if (push && !full) begin
        parse_beat(action_i, ch_i);
        void'(bytes_to_send.pop_front());
        beats_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------------------
  initial begin
    int base_beats;
    int base_ends;
    restart_parse();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling. The spare action is ignored, and an end of text with
    // nothing pending gives nothing.
    set_idling(0, 0);
    add_beat(ACT_SPARE, 8'hFF);
    add_beat(ctlp_pkg::ACT_END, 8'h00);
    add_text("\"T\"\n");             // title, accepted as the first line
    add_text(" #x\n");               // comment only: no result, still counted
    add_text("a/b");                 // a single slash is plain text
    add_byte(CH_NUL);                // a zero byte ends the text like an end action
    add_text("F0/");                 // a slash at the end of the piece stays as text
    add_beat(ctlp_pkg::ACT_END, 8'h00);
    add_text("0123456789abcdef\n");  // code after a description is allowed
    add_text("\"\"\n");              // two quotes alone are too short for a title
    add_beat(ctlp_pkg::ACT_START, 8'h00);
    add_text("x\n");                 // description as the first line: refused, halts
    add_text("y\n");                 // ignored while halted
    add_beat(ctlp_pkg::ACT_END, 8'h00);
    add_beat(ctlp_pkg::ACT_START, 8'h00);
    add_text("\"ab\"\n");
    add_text("FFFFFFFF 00000000\n"); // code right after a title: refused
    wait_drained();

    // Line limit: a piece that fills up is cut, its held slash is text, and the next
    // slash begins the following piece. Then codes with all-ones and all-zero digits.
    add_beat(ctlp_pkg::ACT_START, 8'h00);
    add_text("\"t\"\n");
    add_run(8'h7A, ctlp_pkg::LINE_CHARS - 1);
    add_text("//w\n");
    add_text("ffffffff FFFFFFFF\n");
    add_text("00000000\t00000000\n");
    wait_drained();

    // Back-pressure: the receiver holds off while many short lines arrive, so the line
    // queue fills and full stalls the sender.
    add_beat(ctlp_pkg::ACT_START, 8'h00);
    add_text("\"p\"\n");
    fork
      begin
        rx_held = 1'b1;
        repeat (400) @(posedge clk_i);
        rx_held = 1'b0;
      end
    join_none
    repeat (40) add_text("d\n");
    wait_drained();

    // Random part in four idling phases; the sender pauses for every result in between.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_idling(0, 0);
        1:       set_idling(61, 0);
        2:       set_idling(0, 61);
        default: set_idling(38, 38);
      endcase
      base_beats = beats_queued;
      base_ends  = line_ends;
      while (beats_queued - base_beats < 40 || line_ends - base_ends < 4) begin
        add_random_sequence();
      end
      wait_drained();
    end

    set_idling(0, 0);
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d input beats and %0d result lines (%0d refused lines),",
             beats_taken, lines_checked, refusals_seen);
    $display("line numbers up to %0d, input stall seen: %0d, mismatches: %0d.",
             top_line, input_stalled, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
src/ctlp_pkg.sv
src/ctlp_front.sv
src/ctlp_line_fifo.sv
src/ctlp_back.sv
src/cheat_text_line_parser.sv
tb/cheat_text_line_parser_test.sv
